/* hw/rtl/utf16_to_utf8_transcoder_unit_defines.svh */
// Assertion macros shared by the transcoder RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef UTF16_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U16U8_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define U16U8_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/u16u8_pkg.sv */
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// No dependencies; used by every module of the block.
`default_nettype none

package u16u8_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

    localparam logic [1:0] NB_ONE   = 2'd0;
    localparam logic [1:0] NB_TWO   = 2'd1;
    localparam logic [1:0] NB_THREE = 2'd2;
    localparam logic [1:0] NB_FOUR  = 2'd3;

    // One classified character: its bytes (byte 0 goes out first),
    // byte count minus one, and the error marker.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      nbytes_m1;
        logic            error;
    } char_entry_t;

    typedef struct packed {
        logic pending;
        logic halted;
    } front_status_t;

endpackage

`default_nettype wire

/* hw/rtl/u16u8_front.sv */
// Front end: accepts code units, tracks surrogate pairs and builds byte entries.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_front (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [15:0]             s_code_unit,
    input  wire logic                    s_end_of_input,
    input  wire logic                    q_full,
    output logic                         q_push,
    output u16u8_pkg::char_entry_t       q_push_entry,
    output u16u8_pkg::front_status_t     status
);
    import u16u8_pkg::*;

    logic       pending_reg, pending_next;
    logic [9:0] high_bits_reg, high_bits_next;
    logic       halted_reg, halted_next;
    logic       accept;
    logic       is_high, is_low;
    logic [20:0] cp;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign is_high = (s_code_unit[15:10] == HIGH_SURR_TAG);
    assign is_low  = (s_code_unit[15:10] == LOW_SURR_TAG);
    assign cp      = 21'h10000 + {1'b0, high_bits_reg, s_code_unit[9:0]};
    assign status  = '{pending: pending_reg, halted: halted_reg};

    always_comb begin
        q_push         = 1'b0;
        q_push_entry   = '0;
        pending_next   = pending_reg;
        high_bits_next = high_bits_reg;
        halted_next    = halted_reg;
        if (accept && !halted_reg) begin
            priority if (pending_reg && !is_low) begin
                q_push             = 1'b1;
                q_push_entry.error = 1'b1;
                halted_next        = 1'b1;
                pending_next       = 1'b0;
                high_bits_next     = '0;
            end else if (pending_reg) begin
                q_push                 = 1'b1;
                q_push_entry.bytes[0]  = {5'b11110, cp[20:18]};
                q_push_entry.bytes[1]  = {2'b10, cp[17:12]};
                q_push_entry.bytes[2]  = {2'b10, cp[11:6]};
                q_push_entry.bytes[3]  = {2'b10, cp[5:0]};
                q_push_entry.nbytes_m1 = NB_FOUR;
                pending_next           = 1'b0;
                high_bits_next         = '0;
            end else if (is_low || (is_high && s_end_of_input)) begin
                q_push             = 1'b1;
                q_push_entry.error = 1'b1;
                halted_next        = 1'b1;
            end else if (is_high) begin
                pending_next   = 1'b1;
                high_bits_next = s_code_unit[9:0];
            end else if (s_code_unit[15:7] == '0) begin
                q_push                 = 1'b1;
                q_push_entry.bytes[0]  = {1'b0, s_code_unit[6:0]};
                q_push_entry.nbytes_m1 = NB_ONE;
            end else if (s_code_unit[15:11] == '0) begin
                q_push                 = 1'b1;
                q_push_entry.bytes[0]  = {3'b110, s_code_unit[10:6]};
                q_push_entry.bytes[1]  = {2'b10, s_code_unit[5:0]};
                q_push_entry.nbytes_m1 = NB_TWO;
            end else begin
                q_push                 = 1'b1;
                q_push_entry.bytes[0]  = {4'b1110, s_code_unit[15:12]};
                q_push_entry.bytes[1]  = {2'b10, s_code_unit[11:6]};
                q_push_entry.bytes[2]  = {2'b10, s_code_unit[5:0]};
                q_push_entry.nbytes_m1 = NB_THREE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= 1'b0;
            high_bits_reg <= '0;
            halted_reg    <= 1'b0;
        end else begin
            pending_reg   <= pending_next;
            high_bits_reg <= high_bits_next;
            halted_reg    <= halted_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/u16u8_queue.sv */
// Short FIFO of classified character entries between front and back ends.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_queue #(
    parameter int unsigned DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    push,
    input  wire u16u8_pkg::char_entry_t  push_entry,
    output logic                         full,
    input  wire logic                    pop,
    output u16u8_pkg::char_entry_t       head,
    output logic                         empty
);
    import u16u8_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    char_entry_t slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/u16u8_back.sv */
// Back end: serializes queued entries into one output byte per beat.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_back (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    q_empty,
    input  wire u16u8_pkg::char_entry_t  q_head,
    output logic                         q_pop,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [7:0]                   m_out_byte,
    output logic                         m_last_of_run,
    output logic                         m_error
);
    import u16u8_pkg::*;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_out_byte_reg;
    logic       m_last_reg;
    logic       m_error_reg;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic       last_byte;

    assign load      = (!m_valid_reg || m_ready) && !q_empty;
    assign last_byte = (idx_reg == q_head.nbytes_m1);
    assign q_pop     = load && last_byte;

    always_comb begin
        m_valid_next = m_valid_reg;
        idx_next     = idx_reg;
        if (load) begin
            m_valid_next = 1'b1;
            idx_next     = last_byte ? '0 : idx_reg + 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_out_byte_reg <= q_head.bytes[idx_reg];
            m_last_reg     <= last_byte;
            m_error_reg    <= q_head.error;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_out_byte_reg;
    assign m_last_of_run = m_last_reg;
    assign m_error       = m_error_reg;

endmodule

`default_nettype wire

/* hw/rtl/utf16_to_utf8_transcoder_unit.sv */
// Top level of the UTF-16 to UTF-8 transcoder: front end, entry queue, back end.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back and the defines header.
//
//   Channel | Direction | Handshake          | Payload
//   s_      | in        | s_valid / s_ready  | s_code_unit[15:0], s_end_of_input
//   m_      | out       | m_valid / m_ready  | m_out_byte[7:0], m_last_of_run, m_error
//
// An input beat is classified in the cycle it is accepted; a new one can follow every cycle
// while the entry queue is not full. Output runs one byte per cycle while m_ready is high,
// so an n-byte character takes n output beats; the byte serializer in the back end sets the
// sustained rate for multi-byte text. Each byte passes a queue slot, then the output register.
// aresetn is synchronous and active low; it clears the surrogate state, the halt flag
// and the queue. s_ready drops only while the entry queue is full.
`default_nettype none
`include "utf16_to_utf8_transcoder_unit_defines.svh"

module utf16_to_utf8_transcoder_unit #(
    parameter int unsigned Q_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_code_unit,
    input  wire logic        s_end_of_input,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_last_of_run,
    output logic             m_error
);
    import u16u8_pkg::*;

    logic          q_push;
    char_entry_t   q_push_entry;
    logic          q_full;
    logic          q_pop;
    char_entry_t   q_head;
    logic          q_empty;
    front_status_t front_status;

    // Short names for the conditions that the assertions below look at.
    logic          m_err_beat;
    logic          m_err_done;
    logic          err_beat_ok;
    logic          fe_halted;
    logic          fe_pending;

    // The front end decodes surrogate pairs and turns each character into an entry.
    u16u8_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_code_unit    (s_code_unit),
        .s_end_of_input (s_end_of_input),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_push_entry   (q_push_entry),
        .status         (front_status)
    );

    // The queue lets input keep flowing while the back end works through long characters.
    u16u8_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    // The back end sends the bytes of the head entry, one per beat, through an output register.
    u16u8_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run),
        .m_error       (m_error)
    );

    assign m_err_beat  = m_valid && m_error;
    assign m_err_done  = m_valid && m_ready && m_error;
    assign err_beat_ok = (m_out_byte == 8'd0) && m_last_of_run;
    assign fe_halted   = front_status.halted;
    assign fe_pending  = front_status.pending;

    // An error beat carries a zero byte and closes its run.
    `U16U8_ASSERT_IMP(a_error_beat_form, aclk, aresetn, m_err_beat, err_beat_ok, "bad error beat")
    // Once the error beat leaves, the block is halted and nothing follows it.
    `U16U8_ASSERT_NXT(a_nothing_after_error, aclk, aresetn, m_err_done, !m_valid, "beat after error")
    // A halted front end never holds a high surrogate.
    `U16U8_ASSERT_IMP(a_halt_clears_pending, aclk, aresetn, fe_halted, !fe_pending, "pending in halt")

endmodule

`default_nettype wire
